### rtl/literal_escape_decoder_assert.svh
// assertion macros for the literal escape decoder, used by ldc_back
// expects signals named clk and rst in the scope where a macro is used
`ifndef LITERAL_ESCAPE_DECODER_ASSERT_SVH
`define LITERAL_ESCAPE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, quiet during reset
`define LDC_ASSERT_IMPL(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication, quiet during reset
`define LDC_ASSERT_NEXT(label, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define LDC_ASSERT_IMPL(label, a, b, msg)
`define LDC_ASSERT_NEXT(label, a, b, msg)
`endif

`endif

### rtl/ldc_pkg.sv
// shared types, codes and decode functions for the literal escape decoder
// no dependencies
package ldc_pkg;

  // default depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // result status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_NOT_LIT    = 4'd1;
  localparam logic [3:0] ST_EOF        = 4'd2;
  localparam logic [3:0] ST_NEWLINE    = 4'd3;
  localparam logic [3:0] ST_NO_HEX     = 4'd4;
  localparam logic [3:0] ST_SHORT_HEX  = 4'd5;
  localparam logic [3:0] ST_BAD_ESC    = 4'd6;
  localparam logic [3:0] ST_CHAR_LONG  = 4'd7;
  localparam logic [3:0] ST_CHAR_EMPTY = 4'd8;
  localparam logic [3:0] ST_CP_BIG     = 4'd9;

  // source characters with a special meaning
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_UP_U   = 8'h55;

  // hex digit counts for the short and long unicode escapes
  localparam logic [3:0] HEX_SHORT = 4'd4;
  localparam logic [3:0] HEX_LONG  = 4'd8;

  // largest legal codepoint
  localparam logic [31:0] CP_MAX = 32'h0010_FFFF;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3
  } ldc_phase_t;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_source;
  } ldc_src_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [3:0] status;
  } ldc_dst_t;

  // queued command: one to four bytes, first byte in the low lane
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  last_idx;
    logic        byte_valid;
    logic        last;
    logic [3:0]  status;
  } ldc_cmd_t;

  // hex digit value, msb set when the byte is a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  // single-byte escape letters, msb set when the letter is known
  function automatic logic [8:0] esc_lookup(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      8'h30:     r = {1'b1, 8'h00};      // \0
      CH_SQUOTE: r = {1'b1, CH_SQUOTE};
      CH_DQUOTE: r = {1'b1, CH_DQUOTE};
      8'h6E:     r = {1'b1, 8'h0A};      // \n
      8'h72:     r = {1'b1, 8'h0D};      // \r
      8'h74:     r = {1'b1, 8'h09};      // \t
      8'h76:     r = {1'b1, 8'h0B};      // \v
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/literal_escape_decoder.sv
// top level of the literal escape decoder: front parser, command queue, back emitter
// depends on ldc_pkg, ldc_front, ldc_queue and ldc_back
//
// Usage: source bytes enter one word per cycle on src (valid/ready), starting
// at a literal's opening quote. Each word carries in_byte and end_of_source.
// Decoded bytes, delimiters included, leave on dst (valid/ready) with
// byte_valid, last and status. Every literal, and every error, ends with a
// word that has last set; a byte that opens no literal gives one word with
// status "not literal".
// A word that yields a result is written into the command queue and from
// there into the registered result word on dst, where it waits for dst_ready.
// Throughput: one source word per cycle while the command queue has room; a
// unicode escape that ends in a codepoint of n UTF-8 bytes gives n result
// words on dst, during which src keeps flowing until the command queue
// (QUEUE_DEPTH entries) fills.
// Reset (rst, synchronous): parser returns to waiting for a delimiter, the
// queue empties and dst_valid drops. No clearing pass is needed.
// Stall: while dst_ready is low the result word holds; src_ready falls only
// once the command queue is full.
module literal_escape_decoder import ldc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  ldc_src_t src_word,
  output logic     dst_valid,
  input  logic     dst_ready,
  output ldc_dst_t dst_word
);

  logic     push;
  ldc_cmd_t push_cmd;
  logic     q_not_full;
  logic     pop;
  logic     q_not_empty;
  ldc_cmd_t head;

  // parser
  ldc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_word   (src_word),
    .q_not_full (q_not_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // command queue
  ldc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // emitter
  ldc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .dst_valid   (dst_valid),
    .dst_ready   (dst_ready),
    .dst_word    (dst_word)
  );

endmodule

### rtl/ldc_queue.sv
// command queue between the parser front and the byte emitter back
// depends on ldc_pkg for the command type
module ldc_queue import ldc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  ldc_cmd_t push_cmd,
  output logic     not_full,
  input  logic     pop,
  output logic     not_empty,
  output ldc_cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ldc_cmd_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/ldc_front.sv
// parser front: accepts source words, tracks literal phase, queues commands
// depends on ldc_pkg for types, codes and decode functions
module ldc_front import ldc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  ldc_src_t src_word,
  input  logic     q_not_full,
  output logic     push,
  output ldc_cmd_t push_cmd
);

  ldc_phase_t  phase, phase_next;
  logic        is_char_literal, is_char_literal_next;
  logic        wide_escape, wide_escape_next;
  logic [3:0]  hex_digit_count, hex_digit_count_next;
  logic [31:0] codepoint_acc, codepoint_acc_next;
  logic [1:0]  content_bytes, content_bytes_next;

  logic        fire;
  logic        push_req;
  logic [7:0]  c;
  logic        eos;
  logic [7:0]  delim;
  logic [4:0]  hex_dec;
  logic        hex_ok;
  logic [8:0]  esc_dec;
  logic [31:0] acc_shift;
  logic [3:0]  cnt_inc;
  logic        hex_done;
  logic        cp_big;
  logic        cp_zero;
  logic [31:0] utf_data;
  logic [1:0]  utf_last_idx;
  logic [2:0]  utf_len;
  logic [2:0]  add_one_sum;
  logic [2:0]  add_utf_sum;
  logic [1:0]  content_plus_one;
  logic [1:0]  content_plus_utf;
  logic [3:0]  close_status;

  assign src_ready = q_not_full;
  assign fire      = src_valid && src_ready;
  assign push      = fire && push_req;

  // field decode
  assign c       = src_word.in_byte;
  assign eos     = src_word.end_of_source;
  assign delim   = is_char_literal ? CH_SQUOTE : CH_DQUOTE;
  assign hex_dec = hex_value(c);
  assign hex_ok  = !eos && hex_dec[4];
  assign esc_dec = esc_lookup(c);

  // hex accumulation
  assign acc_shift = {codepoint_acc[27:0], hex_dec[3:0]};
  assign cnt_inc   = hex_digit_count + 4'd1;
  assign hex_done  = cnt_inc >= (wide_escape ? HEX_LONG : HEX_SHORT);
  assign cp_big    = acc_shift > CP_MAX;
  assign cp_zero   = (acc_shift == 32'd0);

  // utf-8 encoding of the finished codepoint
  always_comb begin
    if (acc_shift < 32'h0000_0080) begin
      utf_data     = {24'd0, acc_shift[7:0]};
      utf_last_idx = 2'd0;
    end else if (acc_shift < 32'h0000_0800) begin
      utf_data     = {16'd0, 2'b10, acc_shift[5:0], 3'b110, acc_shift[10:6]};
      utf_last_idx = 2'd1;
    end else if (acc_shift < 32'h0001_0000) begin
      utf_data     = {8'd0, 2'b10, acc_shift[5:0], 2'b10, acc_shift[11:6],
                      4'b1110, acc_shift[15:12]};
      utf_last_idx = 2'd2;
    end else begin
      utf_data     = {2'b10, acc_shift[5:0], 2'b10, acc_shift[11:6],
                      2'b10, acc_shift[17:12], 5'b11110, acc_shift[20:18]};
      utf_last_idx = 2'd3;
    end
  end
  assign utf_len = {1'b0, utf_last_idx} + 3'd1;

  // saturating content counts
  assign add_one_sum      = {1'b0, content_bytes} + 3'd1;
  assign add_utf_sum      = {1'b0, content_bytes} + utf_len;
  assign content_plus_one = (add_one_sum > 3'd2) ? 2'd2 : add_one_sum[1:0];
  assign content_plus_utf = (add_utf_sum > 3'd2) ? 2'd2 : add_utf_sum[1:0];

  // char literal check at the closing quote
  always_comb begin
    close_status = ST_OK;
    if (is_char_literal) begin
      if (content_bytes == 2'd0) close_status = ST_CHAR_EMPTY;
      else if (content_bytes >= 2'd2) close_status = ST_CHAR_LONG;
    end
  end

  // output decode: which command this word queues
  always_comb begin
    push_req            = 1'b0;
    push_cmd            = '0;
    push_cmd.byte_valid = 1'b0;
    push_cmd.last       = 1'b1;
    unique case (phase)
      PH_BODY: begin
        push_req = 1'b1;
        if (eos) begin
          push_cmd.status = ST_EOF;
        end else if (c == CH_NL) begin
          push_cmd.status = ST_NEWLINE;
        end else if (c == CH_BSLASH) begin
          push_req = 1'b0;
        end else begin
          push_cmd.data[7:0]  = c;
          push_cmd.byte_valid = 1'b1;
          push_cmd.last       = (c == delim);
          push_cmd.status     = (c == delim) ? close_status : ST_OK;
        end
      end
      PH_ESC: begin
        push_req = 1'b1;
        if (eos) begin
          push_cmd.status = ST_EOF;
        end else if (c == CH_LOW_U || c == CH_UP_U) begin
          push_req = 1'b0;
        end else if (c == CH_NL) begin
          push_cmd.status = ST_NEWLINE;
        end else if (esc_dec[8]) begin
          push_cmd.data[7:0]  = esc_dec[7:0];
          push_cmd.byte_valid = 1'b1;
          push_cmd.last       = 1'b0;
        end else begin
          push_cmd.status = ST_BAD_ESC;
        end
      end
      PH_HEX: begin
        if (!hex_ok) begin
          push_req        = 1'b1;
          push_cmd.status = (hex_digit_count == 4'd0) ? ST_NO_HEX : ST_SHORT_HEX;
        end else if (hex_done) begin
          if (cp_big) begin
            push_req        = 1'b1;
            push_cmd.status = ST_CP_BIG;
          end else if (!cp_zero) begin
            push_req            = 1'b1;
            push_cmd.data       = utf_data;
            push_cmd.last_idx   = utf_last_idx;
            push_cmd.byte_valid = 1'b1;
            push_cmd.last       = 1'b0;
          end
        end
      end
      default: begin
        push_req = 1'b1;
        if (!eos && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
          push_cmd.data[7:0]  = c;
          push_cmd.byte_valid = 1'b1;
          push_cmd.last       = 1'b0;
        end else begin
          push_cmd.status = ST_NOT_LIT;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    phase_next           = phase;
    is_char_literal_next = is_char_literal;
    wide_escape_next     = wide_escape;
    hex_digit_count_next = hex_digit_count;
    codepoint_acc_next   = codepoint_acc;
    content_bytes_next   = content_bytes;
    unique case (phase)
      PH_BODY: begin
        if (eos || c == CH_NL || c == delim) begin
          phase_next = PH_IDLE;
        end else if (c == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else begin
          content_bytes_next = content_plus_one;
        end
      end
      PH_ESC: begin
        if (eos || c == CH_NL) begin
          phase_next = PH_IDLE;
        end else if (c == CH_LOW_U || c == CH_UP_U) begin
          wide_escape_next     = (c == CH_UP_U);
          hex_digit_count_next = 4'd0;
          codepoint_acc_next   = 32'd0;
          phase_next           = PH_HEX;
        end else if (esc_dec[8]) begin
          content_bytes_next = content_plus_one;
          phase_next         = PH_BODY;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_HEX: begin
        if (!hex_ok) begin
          phase_next = PH_IDLE;
        end else begin
          codepoint_acc_next   = acc_shift;
          hex_digit_count_next = cnt_inc;
          if (hex_done) begin
            if (cp_big) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_BODY;
              if (!cp_zero) content_bytes_next = content_plus_utf;
            end
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (!eos && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
          is_char_literal_next = (c == CH_SQUOTE);
          content_bytes_next   = 2'd0;
          wide_escape_next     = 1'b0;
          hex_digit_count_next = 4'd0;
          codepoint_acc_next   = 32'd0;
          phase_next           = PH_BODY;
        end
      end
    endcase
  end

  // state registers, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      is_char_literal <= 1'b0;
      wide_escape     <= 1'b0;
      hex_digit_count <= 4'd0;
      codepoint_acc   <= 32'd0;
      content_bytes   <= 2'd0;
    end else if (fire) begin
      phase           <= phase_next;
      is_char_literal <= is_char_literal_next;
      wide_escape     <= wide_escape_next;
      hex_digit_count <= hex_digit_count_next;
      codepoint_acc   <= codepoint_acc_next;
      content_bytes   <= content_bytes_next;
    end
  end

endmodule

### rtl/ldc_back.sv
// byte emitter back: walks each queued command and drives the result register
// depends on ldc_pkg and the assertion macros in literal_escape_decoder_assert.svh
`include "literal_escape_decoder_assert.svh"

module ldc_back import ldc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_not_empty,
  input  ldc_cmd_t head,
  output logic     pop,
  output logic     dst_valid,
  input  logic     dst_ready,
  output ldc_dst_t dst_word
);

  logic       load;
  logic [1:0] idx;
  logic       at_end;

  // take the next byte whenever the result register is free or draining
  assign load   = q_not_empty && (!dst_valid || dst_ready);
  assign at_end = (idx == head.last_idx);
  assign pop    = load && at_end;

  // byte index within the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (load) begin
      dst_valid <= 1'b1;
    end else if (dst_ready) begin
      dst_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      dst_word.out_byte   <= head.data[{idx, 3'b000} +: 8];
      dst_word.byte_valid <= head.byte_valid;
      dst_word.last       <= head.last && at_end;
      dst_word.status     <= head.status;
    end
  end

  `LDC_ASSERT_IMPL(a_idx_in_range, q_not_empty, idx <= head.last_idx, "byte index past command end")
  `LDC_ASSERT_IMPL(a_burst_held, idx != 2'd0, q_not_empty, "command left queue mid burst")
  `LDC_ASSERT_IMPL(a_novalid_last, dst_valid && !dst_word.byte_valid, dst_word.last, "error result without last")

endmodule

### test/tb.sv
// testbench for literal_escape_decoder: random and directed source words against a predictor
// depends on ldc_pkg and the literal_escape_decoder rtl
module tb;
  import ldc_pkg::*;

  localparam int RANDOM_WORDS = 200;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    ldc_src_t word;
    bit       drain;
  } src_item_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_ready;
  ldc_src_t src_word = '0;
  logic     dst_valid;
  logic     dst_ready = 1'b0;
  ldc_dst_t dst_word;

  literal_escape_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_word  (dst_word)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // source words waiting to be sent, and decoded words waiting to arrive
  src_item_t src_backlog[$];
  ldc_dst_t  decoded_due[$];
  bit        hold_next = 1'b0;

  // decoder state mirror
  ldc_phase_t  dec_phase = PH_IDLE;
  logic        in_char = 1'b0;
  logic        long_esc = 1'b0;
  logic [3:0]  digits_seen = '0;
  logic [31:0] cp_accum = '0;
  logic [1:0]  body_len = '0;

  // handshake bookkeeping
  logic     src_took = 1'b0;
  logic     dst_took = 1'b0;
  int       src_gap = 0;
  int       dst_stall = 0;
  bit       src_calm = 1'b0;
  bit       dst_calm = 1'b0;
  int       quiet = 0;
  int       n_total = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       n_lits = 0;
  int       n_err = 0;
  int       n_fail = 0;
  ldc_dst_t want;

  // ---------------------------------------------------------------------------
  // predictor

  task automatic emit(input logic [7:0] b, input logic v, input logic l,
                      input logic [3:0] st);
    ldc_dst_t r;
    r.out_byte   = b;
    r.byte_valid = v;
    r.last       = l;
    r.status     = st;
    decoded_due.push_back(r);
  endtask

  task automatic abort_literal(input logic [3:0] st);
    emit(8'h00, 1'b0, 1'b1, st);
    dec_phase = PH_IDLE;
  endtask

  task automatic add_content(input int n);
    int t;
    t = int'(body_len) + n;
    body_len = (t > 2) ? 2'd2 : t[1:0];
  endtask

  // codepoint to utf-8, zero gives nothing, above CP_MAX aborts the literal
  task automatic emit_utf8(input logic [31:0] cp);
    int n;
    n = 0;
    if (cp > CP_MAX) begin
      abort_literal(ST_CP_BIG);
    end else begin
      if (cp == 32'd0) begin
        n = 0;
      end else if (cp < 32'h80) begin
        emit(cp[7:0], 1'b1, 1'b0, ST_OK);
        n = 1;
      end else if (cp < 32'h800) begin
        emit({3'b110, cp[10:6]}, 1'b1, 1'b0, ST_OK);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        n = 2;
      end else if (cp < 32'h10000) begin
        emit({4'b1110, cp[15:12]}, 1'b1, 1'b0, ST_OK);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_OK);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        n = 3;
      end else begin
        emit({5'b11110, cp[20:18]}, 1'b1, 1'b0, ST_OK);
        emit({2'b10, cp[17:12]}, 1'b1, 1'b0, ST_OK);
        emit({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_OK);
        emit({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
        n = 4;
      end
      add_content(n);
      dec_phase = PH_BODY;
    end
  endtask

  task automatic decode_word(input ldc_src_t w);
    logic [7:0] c;
    logic [7:0] closer;
    logic [7:0] d;
    logic [4:0] hv;
    logic [3:0] st;
    logic       known;
    c = w.in_byte;
    case (dec_phase)
      PH_BODY: begin
        closer = in_char ? CH_SQUOTE : CH_DQUOTE;
        if (w.end_of_source) begin
          abort_literal(ST_EOF);
        end else if (c == CH_NL) begin
          abort_literal(ST_NEWLINE);
        end else if (c == CH_BSLASH) begin
          dec_phase = PH_ESC;
        end else if (c == closer) begin
          st = ST_OK;
          if (in_char && body_len == 2'd0) st = ST_CHAR_EMPTY;
          else if (in_char && body_len >= 2'd2) st = ST_CHAR_LONG;
          emit(c, 1'b1, 1'b1, st);
          dec_phase = PH_IDLE;
        end else begin
          emit(c, 1'b1, 1'b0, ST_OK);
          add_content(1);
        end
      end
      PH_ESC: begin
        if (w.end_of_source) begin
          abort_literal(ST_EOF);
        end else if (c == CH_LOW_U || c == CH_UP_U) begin
          long_esc    = (c == CH_UP_U);
          digits_seen = '0;
          cp_accum    = '0;
          dec_phase   = PH_HEX;
        end else if (c == CH_NL) begin
          abort_literal(ST_NEWLINE);
        end else begin
          known = 1'b1;
          d = 8'h00;
          case (c)
            CH_BSLASH: d = CH_BSLASH;
            "0":       d = 8'h00;
            CH_SQUOTE: d = CH_SQUOTE;
            CH_DQUOTE: d = CH_DQUOTE;
            "n":       d = CH_NL;
            "r":       d = 8'h0D;
            "t":       d = 8'h09;
            "v":       d = 8'h0B;
            default:   known = 1'b0;
          endcase
          if (known) begin
            emit(d, 1'b1, 1'b0, ST_OK);
            add_content(1);
            dec_phase = PH_BODY;
          end else begin
            abort_literal(ST_BAD_ESC);
          end
        end
      end
      PH_HEX: begin
        hv = 5'd0;
        if (!w.end_of_source) begin
          if (c >= "0" && c <= "9") begin
            d = c - "0";
            hv = {1'b1, d[3:0]};
          end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
            hv = {1'b1, d[3:0]};
          end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
            hv = {1'b1, d[3:0]};
          end
        end
        if (!hv[4]) begin
          abort_literal(digits_seen == 4'd0 ? ST_NO_HEX : ST_SHORT_HEX);
        end else begin
          cp_accum = {cp_accum[27:0], hv[3:0]};
          digits_seen = digits_seen + 4'd1;
          if (digits_seen >= (long_esc ? HEX_LONG : HEX_SHORT)) emit_utf8(cp_accum);
        end
      end
      default: begin
        if (!w.end_of_source && (c == CH_DQUOTE || c == CH_SQUOTE)) begin
          in_char     = (c == CH_SQUOTE);
          body_len    = '0;
          long_esc    = 1'b0;
          digits_seen = '0;
          cp_accum    = '0;
          dec_phase   = PH_BODY;
          emit(c, 1'b1, 1'b0, ST_OK);
        end else begin
          dec_phase = PH_IDLE;
          emit(8'h00, 1'b0, 1'b1, ST_NOT_LIT);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders

  function automatic int idle_draw(inout bit calm);
    if ($urandom_range(0, 24) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic add_word(input ldc_src_t w);
    src_item_t it;
    it.word  = w;
    it.drain = hold_next;
    hold_next = 1'b0;
    src_backlog.push_back(it);
  endtask

  task automatic add_byte(input logic [7:0] b);
    ldc_src_t w;
    w.in_byte       = b;
    w.end_of_source = 1'b0;
    add_word(w);
  endtask

  // end of source, byte lane carries junk
  task automatic add_end();
    ldc_src_t w;
    w.in_byte       = 8'($urandom_range(0, 255));
    w.end_of_source = 1'b1;
    add_word(w);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // hex digits msb first, letters in random case
  task automatic add_hex(input logic [31:0] v, input int ndig);
    logic [3:0] nib;
    logic [7:0] b;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) b = "0";
      else b = $urandom_range(0, 1) ? "A" : "a";
      b = b + ((nib < 4'd10) ? {4'd0, nib} : {4'd0, nib} - 8'd10);
      add_byte(b);
    end
  endtask

  function automatic logic [31:0] pick_codepoint(input bit wide);
    logic [31:0] cp;
    case ($urandom_range(0, 4))
      0: cp = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: cp = $urandom_range('h800, 'hFFFF);
      3: cp = $urandom_range('h10000, 'h10FFFF);
      default: begin
        case ($urandom_range(0, 5))
          0: cp = 32'h7F;
          1: cp = 32'h80;
          2: cp = 32'h7FF;
          3: cp = 32'h800;
          4: cp = 32'hFFFF;
          default: cp = CP_MAX;
        endcase
      end
    endcase
    if (!wide) cp = cp & 32'h0000_FFFF;
    return cp;
  endfunction

  // one piece of literal content: plain byte, simple escape or unicode escape
  task automatic add_piece(input logic [7:0] closer);
    string      letters;
    logic [7:0] b;
    bit         wide;
    int         r;
    letters = "\\0'\"nrtv";
    r = $urandom_range(0, 9);
    if (r < 5) begin
      do b = 8'($urandom_range(0, 255));
      while (b == CH_BSLASH || b == CH_NL || b == closer);
      add_byte(b);
    end else if (r < 8) begin
      add_byte(CH_BSLASH);
      add_byte(letters[$urandom_range(0, 7)]);
    end else begin
      wide = 1'($urandom_range(0, 1));
      add_byte(CH_BSLASH);
      add_byte(wide ? CH_UP_U : CH_LOW_U);
      add_hex(pick_codepoint(wide), wide ? 8 : 4);
    end
  endtask

  // error at a random point after the opening delimiter
  task automatic add_fault();
    logic [7:0] b;
    bit         wide;
    case ($urandom_range(0, 6))
      0: add_end();
      1: add_byte(CH_NL);
      2: begin
        add_byte(CH_BSLASH);
        add_byte(CH_NL);
      end
      3: begin
        add_byte(CH_BSLASH);
        add_end();
      end
      4: begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {CH_BSLASH, "0", CH_SQUOTE, CH_DQUOTE, "n", "r", "t", "v",
                         CH_LOW_U, CH_UP_U, CH_NL});
        add_byte(CH_BSLASH);
        add_byte(b);
      end
      5: begin
        wide = 1'($urandom_range(0, 1));
        add_byte(CH_BSLASH);
        add_byte(wide ? CH_UP_U : CH_LOW_U);
        add_hex($urandom(), $urandom_range(0, wide ? 7 : 3));
        if ($urandom_range(0, 3) == 0) begin
          add_end();
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
          add_byte(b);
        end
      end
      default: begin
        add_byte(CH_BSLASH);
        add_byte(CH_UP_U);
        add_hex($urandom_range('h110000, 'hFFFF_FFFF), 8);
      end
    endcase
  endtask

  task automatic add_literal(input bit broken);
    bit         is_chr;
    logic [7:0] q;
    int         n;
    is_chr = ($urandom_range(0, 2) == 0);
    q = is_chr ? CH_SQUOTE : CH_DQUOTE;
    if (is_chr) begin
      case ($urandom_range(0, 7))
        0: n = 0;
        1: n = 2;
        default: n = 1;
      endcase
    end else begin
      n = $urandom_range(0, 6);
    end
    add_byte(q);
    repeat (n) add_piece(q);
    if (broken) add_fault();
    else add_byte(q);
  endtask

  // ---------------------------------------------------------------------------
  // source driver: holds a word until taken, then idles for the drawn gap

  always @(negedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (src_valid && !src_took) begin
      // word still waiting
    end else if (src_gap > 0) begin
      src_gap = src_gap - 1;
      src_valid <= 1'b0;
    end else if (src_backlog.size() != 0 &&
                 !(src_backlog[0].drain && decoded_due.size() != 0)) begin
      src_word  <= src_backlog[0].word;
      src_valid <= 1'b1;
      src_backlog.pop_front();
      src_gap = idle_draw(src_calm);
    end else begin
      src_valid <= 1'b0;
    end
  end

  // sink driver: random stall after each word taken
  always @(negedge clk) begin
    if (rst) begin
      dst_ready <= 1'b0;
    end else begin
      if (dst_took) dst_stall = idle_draw(dst_calm);
      if (dst_stall > 0) begin
        dst_ready <= 1'b0;
        dst_stall = dst_stall - 1;
      end else begin
        dst_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each source word, check each result word, watchdog

  always @(posedge clk) begin
    if (rst) begin
      src_took <= 1'b0;
      dst_took <= 1'b0;
    end else begin
      src_took <= src_valid && src_ready;
      dst_took <= dst_valid && dst_ready;
      if (src_valid && src_ready) begin
        decode_word(src_word);
        n_accepted++;
      end
      if (dst_valid && dst_ready) begin
        n_results++;
        if (decoded_due.size() == 0) begin
          $error("result word with nothing expected: out_byte %02h status %0d",
                 dst_word.out_byte, dst_word.status);
          n_fail++;
        end else begin
          want = decoded_due.pop_front();
          if (want.last) n_lits++;
          if (want.status != ST_OK) n_err++;
          if (dst_word.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, dst_word.out_byte);
            n_fail++;
          end
          if (dst_word.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                   dst_word.byte_valid);
            n_fail++;
          end
          if (dst_word.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, dst_word.last);
            n_fail++;
          end
          if (dst_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, dst_word.status);
            n_fail++;
          end
        end
      end
      if ((src_valid && src_ready) || (dst_valid && dst_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run

  initial begin
    int         n_directed;
    int         next_hold;
    int         r;
    logic [7:0] b;

    // idle: end of source and bytes that open nothing
    add_end();
    add_byte(8'hFF);
    add_byte(8'h00);
    // char literals: empty, too long, escaped, double quote as plain content
    add_text("''");
    add_text("'ab'");
    add_text("'\\n'");
    add_text("'\"'");
    // every simple escape except \n, single quote as plain content
    add_text("\"'\\\\\\0\\'\\\"\\r\\t\\v\"");
    // codepoint zero, largest codepoint, surrogate, two-byte edge
    add_text("\"\\u0000\\U0010FFFF\\uD800\\u07ff\\u0041\"");
    // errors
    add_text("\"\\U00110000");
    add_text("\"\\uZ");
    add_text("\"\\u12g");
    add_text("\"\\q");
    add_text("\"\n");
    add_text("'\\\n");
    add_text("\"");
    add_end();
    add_text("\"\\");
    add_end();
    add_text("\"\\u1");
    add_end();
    add_text("\"\\u");
    add_end();
    n_directed = src_backlog.size();

    // random part: mostly well-formed literals, some broken ones and noise
    next_hold = n_directed;
    while (src_backlog.size() < n_directed + RANDOM_WORDS) begin
      if (src_backlog.size() >= next_hold) begin
        hold_next = 1'b1;
        next_hold += 80;
      end
      r = $urandom_range(0, 9);
      if (r < 7) begin
        add_literal(1'b0);
      end else if (r < 9) begin
        add_literal(1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 4) == 0) begin
            add_end();
          end else begin
            do b = 8'($urandom_range(0, 255));
            while (b == CH_SQUOTE || b == CH_DQUOTE);
            add_byte(b);
          end
        end
      end
    end
    n_total = src_backlog.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(negedge clk);
    while (decoded_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d source words; checked %0d result words closing %0d literals",
             n_accepted, n_results, n_lits);
    $display("%0d of the result words carried an error or not-literal status", n_err);
    if (n_fail == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
